[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/idp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idp_pkg
// Shared types and constants of the DIB icon pixel decoder.
// ---------------------------------------------------------------------------
package idp_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_DIMENSION_DEF = 8192;

	localparam int BPP_W   = 6;
	localparam int COLORS_W = 9;
	localparam int DIM_W   = 14;
	localparam int POS_W   = 13;
	localparam int CFG_W   = 14;
	localparam int CFG_IDX_W = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BPP       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLORS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ORDER = 3'd4;

	// reset values
	localparam logic [BPP_W-1:0]    BPP_RST    = 6'd32;
	localparam logic [COLORS_W-1:0] COLORS_RST = 9'd0;
	localparam logic [DIM_W-1:0]    WIDTH_RST  = 14'd16;
	localparam logic [DIM_W-1:0]    HEIGHT_RST = 14'd16;

	// decoded depths
	localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
	localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
	localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
	localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
	localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

	// item kinds
	localparam logic FUNC_PAL_WRITE = 1'b0;
	localparam logic FUNC_DECODE    = 1'b1;

	typedef struct packed {
		logic [BPP_W-1:0]    bpp;
		logic [COLORS_W-1:0] colors;
		logic [DIM_W-1:0]    width;
		logic [DIM_W-1:0]    height;
		logic                top_first;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       alpha;
		logic [7:0]       mask_alpha;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             alpha_seen;
		logic             last;
		logic             use_pal;
	} pix_t;

endpackage

[sv/ico_dib_pixel_decoder_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_dib_pixel_decoder_unit
// DIB icon pixel decoder: palette RAM plus tracking, one pixel per cycle.
// ---------------------------------------------------------------------------
//
//  channel | signals                         | moves
//  --------+---------------------------------+-----------------------------
//  in      | in_valid / in_ready             | palette write or pixel item
//  out     | out_valid / out_ready           | one RGBA result per pixel
//  cfg     | cfg_write, cfg_index, cfg_data  | register write, no wait
//
//  One item per cycle sustained while the output is not stalled. The accept
//  edge of a pixel item loads s1 and the palette read data together; s1
//  then moves into the output register once that register is free.
//  Palette write items produce no result and finish at accept.
//  Reset clears counters, flag, config and valid bits; the palette is
//  undefined until written. A stalled output backs up s1 and then in_ready.
//
module ico_dib_pixel_decoder_unit
	import idp_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// config
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input items
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [7:0]           palette_index,
	input  logic [23:0]          palette_color,
	input  logic [31:0]          pixel_bytes,
	input  logic [7:0]           mask_byte,
	// result items
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic [7:0]           alpha,
	output logic [7:0]           mask_alpha,
	output logic [POS_W-1:0]     pos_x,
	output logic [POS_W-1:0]     pos_y,
	output logic                 alpha_seen,
	output logic                 last
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [8:0] PAL_LIM = 9'(PALETTE_DEPTH);

	// config registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp       <= BPP_RST;
			cfg_q.colors    <= COLORS_RST;
			cfg_q.width     <= WIDTH_RST;
			cfg_q.height    <= HEIGHT_RST;
			cfg_q.top_first <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BPP:       cfg_q.bpp       <= cfg_data[BPP_W-1:0];
				REG_COLORS:    cfg_q.colors    <= cfg_data[COLORS_W-1:0];
				REG_WIDTH:     cfg_q.width     <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    cfg_q.height    <= cfg_data[DIM_W-1:0];
				REG_ROW_ORDER: cfg_q.top_first <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves whenever the output register is free or drains
	logic s1_valid_q, out_valid_q;
	logic out_free, s1_adv, accept, dec_acc, pal_we;

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid_q && out_free;
	assign in_ready = !s1_valid_q || out_free;
	assign accept   = in_valid && in_ready;
	assign dec_acc  = accept && (func == FUNC_DECODE);
	// writes past the palette depth are dropped
	assign pal_we   = accept && (func == FUNC_PAL_WRITE) && ({1'b0, palette_index} < PAL_LIM);

	// tracking and per-pixel decode, evaluated in the accept cycle
	pix_t          pix;
	logic [AW-1:0] rd_addr;

	idp_track #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.MAX_DIMENSION (MAX_DIMENSION),
		.AW            (AW)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step        (dec_acc),
		.pixel_bytes (pixel_bytes),
		.mask_byte   (mask_byte),
		.pix         (pix),
		.pal_addr    (rd_addr)
	);

	// palette RAM; read data only moves on a decode accept, so it holds
	// while s1 is stalled
	logic [23:0] rd_data;

	idp_pal_ram #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (AW)
	) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (palette_index[AW-1:0]),
		.wdata (palette_color),
		.re    (dec_acc),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// s1: decoded fields wait for the palette read
	pix_t pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (dec_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			pix_s1 <= pix;
		end
	end

	// output register
	pix_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= pix_s1;
			if (pix_s1.use_pal) begin
				out_q.blue  <= rd_data[7:0];
				out_q.green <= rd_data[15:8];
				out_q.red   <= rd_data[23:16];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = out_q.red;
	assign green      = out_q.green;
	assign blue       = out_q.blue;
	assign alpha      = out_q.alpha;
	assign mask_alpha = out_q.mask_alpha;
	assign pos_x      = out_q.pos_x;
	assign pos_y      = out_q.pos_y;
	assign alpha_seen = out_q.alpha_seen;
	assign last       = out_q.last;

endmodule

[sv/idp_pal_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idp_pal_ram
// Palette memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module idp_pal_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/idp_track.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idp_track
// Column / row tracking, pixel select, unpack, mask and alpha flag.
// ---------------------------------------------------------------------------
module idp_track
	import idp_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int AW            = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          step,
	input  logic [31:0]   pixel_bytes,
	input  logic [7:0]    mask_byte,
	output pix_t          pix,
	output logic [AW-1:0] pal_addr
);

	localparam logic [DIM_W-1:0]    MAX_DIM = DIM_W'(MAX_DIMENSION);
	localparam logic [COLORS_W-1:0] PAL_LIM = COLORS_W'(PALETTE_DEPTH);

	logic [POS_W-1:0] col_q, row_q;
	logic             flag_q;

	logic [DIM_W-1:0]    w, h, col_inc, row_inc, flip;
	logic [COLORS_W-1:0] size, idx9;
	logic [7:0]          idx, lo;
	logic                mbit, pal_depth, row_end, img_end, flag_nx;

	always_comb begin
		w = (cfg.width == '0) ? DIM_W'(1) : ((cfg.width > MAX_DIM) ? MAX_DIM : cfg.width);
		h = (cfg.height == '0) ? DIM_W'(1) : ((cfg.height > MAX_DIM) ? MAX_DIM : cfg.height);
		lo = pixel_bytes[7:0];

		pal_depth = (cfg.bpp == BPP_8) || (cfg.bpp == BPP_4) || (cfg.bpp == BPP_1);
		size = (cfg.colors == '0) ? (COLORS_W'(1) << cfg.bpp[3:0]) : cfg.colors;

		case (cfg.bpp)
			BPP_8:   idx = lo;
			BPP_4:   idx = {4'd0, (col_q[0] ? lo[3:0] : lo[7:4])};
			default: idx = {7'd0, lo[~col_q[2:0]]};
		endcase
		idx9 = {1'b0, idx};
		pal_addr = AW'(idx);

		mbit = mask_byte[~col_q[2:0]];

		pix = '0;
		pix.use_pal = pal_depth && (idx9 < size) && (idx9 < PAL_LIM);
		pix.alpha = 8'hFF;
		if (cfg.bpp == BPP_32) begin
			pix.blue  = pixel_bytes[7:0];
			pix.green = pixel_bytes[15:8];
			pix.red   = pixel_bytes[23:16];
			pix.alpha = pixel_bytes[31:24];
		end else if (cfg.bpp == BPP_24) begin
			pix.blue  = pixel_bytes[7:0];
			pix.green = pixel_bytes[15:8];
			pix.red   = pixel_bytes[23:16];
		end
		if (cfg.bpp != BPP_32 && mbit) begin
			pix.alpha = 8'h00;
		end
		pix.mask_alpha = mbit ? 8'h00 : 8'hFF;

		flag_nx = flag_q || (pix.alpha != 8'h00);
		pix.alpha_seen = flag_nx;

		// bottom-up flip wraps mod the position range
		flip = h - DIM_W'(1) - {1'b0, row_q};
		pix.pos_x = col_q;
		pix.pos_y = cfg.top_first ? row_q : flip[POS_W-1:0];

		col_inc = {1'b0, col_q} + DIM_W'(1);
		row_inc = {1'b0, row_q} + DIM_W'(1);
		row_end = (col_inc >= w);
		img_end = row_end && (row_inc >= h);
		pix.last = img_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			flag_q <= 1'b0;
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_inc[POS_W-1:0];
			end else begin
				col_q <= col_inc[POS_W-1:0];
			end
			flag_q <= img_end ? 1'b0 : flag_nx;
		end
	end

endmodule

[sv/idp_chk.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// idp_chk
// Port-level checks of the DIB icon pixel decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module idp_chk
	import idp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [7:0]       red,
	input logic [7:0]       alpha,
	input logic [7:0]       mask_alpha,
	input logic [POS_W-1:0] pos_x,
	input logic             alpha_seen,
	input logic             last
);

	logic stall;
	assign stall = out_valid && !out_ready;

	`ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(red) && $stable(pos_x) && $stable(last), "stalled result changed")
	`ASSERT_SAME(a_seen_flag, out_valid && (alpha != 8'h00), alpha_seen, "nonzero alpha without alpha_seen")
	`ASSERT_SAME(a_mask_code, out_valid, (mask_alpha == 8'h00) || (mask_alpha == 8'hFF), "mask alpha not 0 or 255")
	`ASSERT_NEXT(a_col_after_last, out_valid && out_ready && last, !out_valid || (pos_x == '0), "image did not restart at column zero")

endmodule

bind ico_dib_pixel_decoder_unit idp_chk u_idp_chk (.*);

[dv/ico_dib_pixel_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ico_dib_pixel_decoder_unit_tb
// Self-checking bench: palette fill, directed corners, randomized image phases.
// Every accepted item runs through a local decode model; each result pixel is
// compared field by field, in order, against the oldest predicted pixel.
// ---------------------------------------------------------------------------
import idp_pkg::*;

typedef struct packed {
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	logic [7:0]       alpha;
	logic [7:0]       mask_alpha;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic             alpha_seen;
	logic             last;
} pixel_t;

class pixel_scoreboard;
	localparam int PRINT_LIMIT = 200;

	logic [23:0]         palette [PALETTE_DEPTH_DEF];
	int unsigned         column;
	int unsigned         row;
	bit                  alpha_flag;
	logic [BPP_W-1:0]    depth;
	logic [COLORS_W-1:0] colors;
	logic [DIM_W-1:0]    width;
	logic [DIM_W-1:0]    height;
	logic                top_first;
	pixel_t              expected_pixels[$];
	int unsigned         results_seen;
	int unsigned         errors;

	function new();
		depth        = BPP_RST;
		colors       = COLORS_RST;
		width        = WIDTH_RST;
		height       = HEIGHT_RST;
		top_first    = 1'b0;
		column       = 0;
		row          = 0;
		alpha_flag   = 1'b0;
		results_seen = 0;
		errors       = 0;
	endfunction

	function int pending();
		return expected_pixels.size();
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_BPP:       depth     = data[BPP_W-1:0];
			REG_COLORS:    colors    = data[COLORS_W-1:0];
			REG_WIDTH:     width     = data[DIM_W-1:0];
			REG_HEIGHT:    height    = data[DIM_W-1:0];
			REG_ROW_ORDER: top_first = data[0];
			default: ;
		endcase
	endfunction

	function int unsigned clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIMENSION_DEF)
			return MAX_DIMENSION_DEF;
		return v;
	endfunction

	// palette writes update the local copy; pixels yield one predicted result
	function void note_item(logic f, logic [7:0] entry, logic [23:0] entry_color,
	                        logic [31:0] bytes, logic [7:0] mbyte);
		int unsigned w, h, x, size, idx, flip;
		logic [23:0] color;
		logic        mbit;
		pixel_t      p;
		if (f == FUNC_PAL_WRITE) begin
			palette[entry] = entry_color;
			return;
		end
		w     = clamp_dim(width);
		h     = clamp_dim(height);
		x     = column;
		size  = 0;
		color = '0;
		p     = '0;
		p.alpha = 8'hFF;
		if (depth <= BPP_8)
			size = (colors == 0) ? (1 << depth) : colors;
		if (depth == BPP_32) begin
			{p.alpha, p.red, p.green, p.blue} = bytes;
		end else if (depth == BPP_24) begin
			{p.red, p.green, p.blue} = bytes[23:0];
		end else if (depth == BPP_8 || depth == BPP_4 || depth == BPP_1) begin
			if (depth == BPP_8)
				idx = bytes[7:0];
			else if (depth == BPP_4)
				idx = (x % 2) ? bytes[3:0] : bytes[7:4];
			else
				idx = bytes[7 - (x % 8)];
			if (idx < size)
				color = palette[idx];
			{p.red, p.green, p.blue} = color;
		end
		mbit = mbyte[7 - (x % 8)];
		if (depth != BPP_32 && mbit)
			p.alpha = 8'h00;
		if (p.alpha != 0)
			alpha_flag = 1'b1;
		flip = top_first ? row : (h - 1 - row);
		p.mask_alpha = mbit ? 8'h00 : 8'hFF;
		p.pos_x      = POS_W'(x);
		p.pos_y      = POS_W'(flip);
		p.alpha_seen = alpha_flag;
		if (column + 1 >= w) begin
			column = 0;
			if (row + 1 >= h) begin
				p.last     = 1'b1;
				row        = 0;
				alpha_flag = 1'b0;
			end else begin
				row = (row + 1) % MAX_DIMENSION_DEF;
			end
		end else begin
			column = (column + 1) % MAX_DIMENSION_DEF;
		end
		expected_pixels.insert(expected_pixels.size(), p);
	endfunction

	task report_mismatch(string msg);
		if (errors < PRINT_LIMIT)
			$display("MISMATCH result %0d: %s", results_seen, msg);
		errors++;
	endtask

	task check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
	endtask

	task check_pixel(pixel_t got);
		pixel_t want;
		results_seen++;
		if (expected_pixels.size() == 0) begin
			report_mismatch("pixel out with nothing pending");
			return;
		end
		want = expected_pixels.pop_front();
		check_field("red", want.red, got.red);
		check_field("green", want.green, got.green);
		check_field("blue", want.blue, got.blue);
		check_field("alpha", want.alpha, got.alpha);
		check_field("mask_alpha", want.mask_alpha, got.mask_alpha);
		check_field("pos_x", want.pos_x, got.pos_x);
		check_field("pos_y", want.pos_y, got.pos_y);
		check_field("alpha_seen", want.alpha_seen, got.alpha_seen);
		check_field("last", want.last, got.last);
	endtask
endclass

module ico_dib_pixel_decoder_unit_tb;

	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 12;
	// accept, palette read, output register, plus margin
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int NUM_PHASES      = 18;
	localparam int ITEMS_PER_PHASE = 75;
	// first index past the register list; writes there must be dropped
	localparam int FIRST_SPARE_REG = REG_ROW_ORDER + 1;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic                 func          = FUNC_PAL_WRITE;
	logic [7:0]           palette_index = '0;
	logic [23:0]          palette_color = '0;
	logic [31:0]          pixel_bytes   = '0;
	logic [7:0]           mask_byte     = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic [7:0]           mask_alpha;
	logic [POS_W-1:0]     pos_x;
	logic [POS_W-1:0]     pos_y;
	logic                 alpha_seen;
	logic                 last;

	pixel_scoreboard decode_sb;
	int unsigned     send_idle_pct = 0;
	int unsigned     stall_pct     = 0;
	int unsigned     quiet_cycles  = 0;

	always #HALF_PERIOD clk = ~clk;

	ico_dib_pixel_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.pixel_bytes   (pixel_bytes),
		.mask_byte     (mask_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.mask_alpha    (mask_alpha),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.alpha_seen    (alpha_seen),
		.last          (last)
	);

	// Input side monitor. Register writes and accepted items feed the model in
	// edge order; both are sampled before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && cfg_write)
			decode_sb.set_reg(cfg_index, cfg_data);
		if (arst_n && in_valid && in_ready)
			decode_sb.note_item(func, palette_index, palette_color, pixel_bytes, mask_byte);
	end

	// Output side: check the pixel taken at this edge, then pick the next
	// ready level. Stalls are per cycle so they hit every pipeline stage.
	always @(posedge clk) begin
		pixel_t got;
		if (arst_n && out_valid && out_ready) begin
			got.red        = red;
			got.green      = green;
			got.blue       = blue;
			got.alpha      = alpha;
			got.mask_alpha = mask_alpha;
			got.pos_x      = pos_x;
			got.pos_y      = pos_y;
			got.alpha_seen = alpha_seen;
			got.last       = last;
			decode_sb.check_pixel(got);
		end
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Hang detector: any handshake or register write restarts the count.
	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input idle_mode_e mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 46; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 46; end
			default:       begin send_idle_pct = 33; stall_pct = 33; end
		endcase
	endtask

	// Present one item, with random idle cycles ahead of it, and hold it
	// until taken. Valid stays high between back-to-back items.
	task automatic send_item(input logic f, input logic [7:0] entry,
	                         input logic [23:0] entry_color, input logic [31:0] bytes,
	                         input logic [7:0] mbyte);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		palette_index <= entry;
		palette_color <= entry_color;
		pixel_bytes   <= bytes;
		mask_byte     <= mbyte;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_pixel(input logic [31:0] bytes, input logic [7:0] mbyte);
		send_item(FUNC_DECODE, 8'($urandom), 24'($urandom), bytes, mbyte);
	endtask

	// Stop sending and wait until every predicted pixel has come out. The
	// extra edge lets the monitor log the final item before we poll.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decode_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all registers back to back while the block is idle. Bits above
	// each register's width carry junk, and a spare index gets a write too.
	task automatic program_regs(input logic [BPP_W-1:0] bpp, input logic [COLORS_W-1:0] ncolors,
	                            input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
	                            input logic td);
		logic [CFG_W-1:0] junk;
		drain();
		junk      = CFG_W'($urandom);
		cfg_write <= 1'b1;
		cfg_index <= REG_BPP;
		cfg_data  <= {junk[CFG_W-1:BPP_W], bpp};
		@(posedge clk);
		cfg_index <= REG_COLORS;
		cfg_data  <= {junk[CFG_W-1:COLORS_W], ncolors};
		@(posedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		junk      = CFG_W'($urandom);
		cfg_index <= REG_ROW_ORDER;
		cfg_data  <= {junk[CFG_W-1:1], td};
		@(posedge clk);
		cfg_index <= CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, 2**CFG_IDX_W - 1));
		cfg_data  <= CFG_W'($urandom);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Random item. Dark phases mostly zero the alpha byte and set every mask
	// bit, so images finish with the nonzero-alpha flag both low and high.
	task automatic send_random(input bit dark);
		logic [31:0] bytes;
		logic [7:0]  mbyte;
		bytes = $urandom;
		mbyte = 8'($urandom);
		if (dark && $urandom_range(0, 19) != 0) begin
			bytes[31:24] = '0;
			mbyte        = '1;
		end
		if ($urandom_range(0, 4) == 0)
			send_item(FUNC_PAL_WRITE, 8'($urandom), 24'($urandom), bytes, mbyte);
		else
			send_item(FUNC_DECODE, 8'($urandom), 24'($urandom), bytes, mbyte);
	endtask

	initial begin
		logic [BPP_W-1:0]    bpp;
		logic [COLORS_W-1:0] ncolors;
		logic [DIM_W-1:0]    w;
		logic [DIM_W-1:0]    h;
		bit                  dark;

		decode_sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Fill the whole palette first so no pixel can ever read an entry that
		// was never written.
		set_idling(IDLE_SENDER);
		for (int i = 0; i < PALETTE_DEPTH_DEF; i++)
			send_item(FUNC_PAL_WRITE, 8'(i), 24'($urandom), $urandom, 8'($urandom));

		// ---- directed corners ----
		set_idling(IDLE_BOTH);

		// 1 bpp, zero width and height count as 1: each pixel is a whole image
		program_regs(BPP_1, 9'd0, 14'd0, 14'd0, 1'b0);
		send_pixel(32'hFFFF_FFFF, 8'h00);
		send_pixel(32'h0000_0000, 8'hFF);

		// 4 bpp, three colors: nibbles 3 and F fall past the palette -> black
		program_regs(BPP_4, 9'd3, 14'd2, 14'd2, 1'b1);
		send_pixel(32'h0000_0021, 8'h80);
		send_pixel(32'h0000_0021, 8'h40);
		send_pixel(32'h0000_00F3, 8'h00);
		send_pixel(32'h0000_003F, 8'hFF);

		// 8 bpp, full palette, extreme entries rewritten just before use
		program_regs(BPP_8, 9'd256, 14'd2, 14'd1, 1'b0);
		send_item(FUNC_PAL_WRITE, 8'h00, 24'h000000, 32'h0, 8'h00);
		send_item(FUNC_PAL_WRITE, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 8'hFF);
		send_pixel(32'hFFFF_FF00, 8'h7F);
		send_pixel(32'h0000_00FF, 8'hBF);

		// 24 bpp, all ones and all zeros
		program_regs(BPP_24, 9'd0, 14'd2, 14'd1, 1'b0);
		send_pixel(32'hFFFF_FFFF, 8'hFF);
		send_pixel(32'h0000_0000, 8'h00);

		// 32 bpp: alpha taken raw, mask only shows up in mask_alpha
		program_regs(BPP_32, 9'h1FF, 14'd2, 14'd1, 1'b1);
		send_pixel(32'h00FF_FFFF, 8'hFF);
		send_pixel(32'hFF00_0000, 8'h00);

		// depth that is not decoded: black, alpha from the mask
		program_regs(6'h3F, 9'd0, 14'd1, 14'd1, 1'b0);
		send_pixel(32'hA5A5_A5A5, 8'hAA);

		// height cut mid-image: row 4 of a now 2-row image closes it and the
		// bottom-up flip wraps around
		program_regs(BPP_24, 9'd0, 14'd1, 14'd6, 1'b0);
		repeat (4) send_pixel($urandom, 8'($urandom));
		program_regs(BPP_24, 9'd0, 14'd1, 14'd2, 1'b0);
		send_pixel($urandom, 8'($urandom));

		// ---- random phases ----
		// Idling mode and depth change every phase, the depth cycling through six;
		// counters carry over between phases, so new geometry often lands mid-image.
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_idling(idle_mode_e'(p % 4));
			case (p % 6)
				0: bpp = BPP_1;
				1: bpp = BPP_4;
				2: bpp = BPP_8;
				3: bpp = BPP_24;
				4: bpp = BPP_32;
				default: begin
					do
						bpp = BPP_W'($urandom);
					while (bpp == BPP_1 || bpp == BPP_4 || bpp == BPP_8 ||
					       bpp == BPP_24 || bpp == BPP_32);
				end
			endcase
			case ($urandom_range(0, 3))
				0: ncolors = '0;
				1: ncolors = '1;
				2: ncolors = COLORS_W'(PALETTE_DEPTH_DEF);
				default: ncolors = COLORS_W'($urandom_range(1, 20));
			endcase
			case (p)
				5: begin
					w = '0;
					h = '0;
				end
				11: begin
					// both clamp to the largest image size
					w = '1;
					h = '1;
				end
				14: begin
					w = DIM_W'(MAX_DIMENSION_DEF);
					h = 14'd1;
				end
				default: begin
					w = DIM_W'($urandom_range(1, 9));
					h = DIM_W'($urandom_range(1, 6));
				end
			endcase
			program_regs(bpp, ncolors, w, h, 1'($urandom));
			dark = ($urandom_range(0, 2) == 0);
			repeat (ITEMS_PER_PHASE) send_random(dark);
		end

		drain();
		if (decode_sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/idp_pkg.sv
sv/idp_pal_ram.sv
sv/idp_track.sv
sv/ico_dib_pixel_decoder_unit.sv
sv/idp_chk.sv
dv/ico_dib_pixel_decoder_unit_tb.sv
